/* rtl/core/kvt_pkg.sv */
`timescale 1ns / 1ps

package kvt_pkg;

	// Default number of table entries.
	localparam int unsigned ENTRIES_DEF = 16;

	// Field widths.
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 3;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_DEFINE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// Request and commit controls broadcast to every cell.
	typedef struct packed {
		logic signed [KEY_W-1:0]   key;
		logic signed [VALUE_W-1:0] value;
		logic                      commit;
		logic                      do_update;
		logic                      do_insert;
		logic                      do_delete;
	} cell_ctl_t;

	// What each cell reports back after its compare.
	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] hit_value;
	} cell_sts_t;

endpackage

/* rtl/core/kvt_cell.sv */
`timescale 1ns / 1ps

module kvt_cell
	import kvt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      claim_in,
	output logic      claim_out,
	output cell_sts_t sts
);

	logic signed [KEY_W-1:0]   key_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;
	logic                      hit_s1;
	logic                      take_free;

	// A free cell takes an insert only if no lower cell has claimed it already.
	assign take_free = ~valid_q & ~claim_in;
	assign claim_out = claim_in | ~valid_q;

	// The compare result is registered, so the resolve cycle sees a stable hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			hit_s1 <= valid_q && (key_q == ctl.key);
			if (ctl.commit) begin
				if (ctl.do_insert && take_free) begin
					valid_q <= 1'b1;
				end else if (ctl.do_delete && hit_s1) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	// Stored key and value need no reset; they are only used while valid.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (ctl.do_insert && take_free) begin
				key_q   <= ctl.key;
				value_q <= ctl.value;
			end else if (ctl.do_update && hit_s1) begin
				value_q <= ctl.value;
			end
		end
	end

	// Keys are unique, so at most one cell drives a non-zero value.
	assign sts.hit       = hit_s1;
	assign sts.hit_value = hit_s1 ? value_q : '0;

endmodule

/* rtl/core/key_value_table.sv */
`timescale 1ns / 1ps
// A request passes the request register, the compare phase in every cell and the resolve
// phase that walks the free-slot claim along the cell chain; an output stall holds the
// resolve phase. A new request is taken while idle or as the previous one resolves.
// Reset: arst_n clears all entry valid bits and the control state at once;
// the table is empty and ready as soon as reset is released.

module key_value_table
	import kvt_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [KIND_W-1:0]          kind,
	input  logic signed [KEY_W-1:0]    key,
	input  logic signed [VALUE_W-1:0]  value_in,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [STATUS_W-1:0]        status,
	output logic                       found,
	output logic signed [VALUE_W-1:0]  value_out
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_CMP  = 2'd1;
	localparam logic [1:0] P_RES  = 2'd2;

	logic [1:0]                 phase_q;
	logic [KIND_W-1:0]          kind_q;
	logic signed [KEY_W-1:0]    key_q;
	logic signed [VALUE_W-1:0]  value_q;

	logic                       rsp_valid_q;
	logic [STATUS_W-1:0]        status_q;
	logic                       found_q;
	logic signed [VALUE_W-1:0]  value_out_q;

	logic                       out_free;
	logic                       resolve;
	logic                       accept;
	logic                       any_hit;
	logic                       full;
	logic signed [VALUE_W-1:0]  hit_value;
	logic [STATUS_W-1:0]        status_d;
	logic                       found_d;
	logic signed [VALUE_W-1:0]  value_d;

	cell_ctl_t                  ctl;
	cell_sts_t                  sts [ENTRIES];
	logic [ENTRIES:0]           claim;

	// Handshake: a new word may enter as the previous one resolves.
	assign out_free  = ~rsp_valid_q | ~rsp_stall;
	assign resolve   = (phase_q == P_RES) && out_free;
	assign req_stall = ~((phase_q == P_IDLE) || resolve);
	assign accept    = req_valid & ~req_stall;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
		end else begin
			case (phase_q)
				P_IDLE: if (accept) phase_q <= P_CMP;
				P_CMP:  phase_q <= P_RES;
				P_RES:  if (resolve) phase_q <= accept ? P_CMP : P_IDLE;
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value_in;
		end
	end

	// Gather the hits and the single hit value from the cells.
	always_comb begin
		any_hit   = 1'b0;
		hit_value = '0;
		for (int i = 0; i < int'(ENTRIES); i++) begin
			any_hit   = any_hit | sts[i].hit;
			hit_value = hit_value | sts[i].hit_value;
		end
	end
	assign full = ~claim[ENTRIES];

	// Controls broadcast to the cells.
	always_comb begin
		ctl.key       = key_q;
		ctl.value     = value_q;
		ctl.commit    = resolve;
		ctl.do_update = (kind_q == KIND_DEFINE) && any_hit;
		ctl.do_insert = (kind_q == KIND_DEFINE) && !any_hit;
		ctl.do_delete = (kind_q == KIND_DELETE);
	end

	// The chain of cells; the claim bit ripples from the lowest entry upwards.
	assign claim[0] = 1'b0;
	for (genvar g = 0; g < int'(ENTRIES); g++) begin : g_cell
		kvt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.claim_in  (claim[g]),
			.claim_out (claim[g+1]),
			.sts       (sts[g])
		);
	end

	// Result word.
	always_comb begin
		status_d = ST_MISS;
		found_d  = 1'b0;
		value_d  = '0;
		case (kind_q)
			KIND_DEFINE: begin
				found_d = any_hit;
				if (any_hit) begin
					status_d = ST_UPDATED;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_INSERTED;
				end
			end
			KIND_LOOKUP: begin
				found_d = any_hit;
				if (any_hit) begin
					status_d = ST_HIT;
					value_d  = hit_value;
				end
			end
			KIND_DELETE: begin
				found_d = any_hit;
				if (any_hit) begin
					status_d = ST_HIT;
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (resolve) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			status_q    <= status_d;
			found_q     <= found_d;
			value_out_q <= value_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign value_out = value_out_q;

endmodule

/* test/tb_key_value_table.sv */
`timescale 1ns / 1ps

module tb_key_value_table
	import kvt_pkg::*;
();

	// The package names no code for the fourth request kind; it must be ignored.
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7fff_ffff;
	localparam int               POOL_LEN = 20;

	// One result word as the table should return it.
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [VALUE_W-1:0]  value;
	} kv_result_t;

	// Mirror of the table contents and the queue of results still to come.
	class kvt_scoreboard;
		logic [KEY_W-1:0]   slot_key [ENTRIES_DEF];
		logic [VALUE_W-1:0] slot_value [ENTRIES_DEF];
		bit                 slot_used [ENTRIES_DEF];
		kv_result_t         awaited [$];
		int                 mismatches;

		function new();
			for (int i = 0; i < ENTRIES_DEF; i++) begin
				slot_used[i] = 1'b0;
			end
			mismatches = 0;
		endfunction

		// Applies one accepted request to the mirror and queues its result.
		function void note_request(logic [KIND_W-1:0] k, logic [KEY_W-1:0] kk,
				logic [VALUE_W-1:0] v);
			kv_result_t r;
			int hit;
			int spare;
			hit = -1;
			spare = -1;
			for (int i = ENTRIES_DEF - 1; i >= 0; i--) begin
				if (slot_used[i] && slot_key[i] == kk)
					hit = i;
				if (!slot_used[i])
					spare = i;
			end
			r.status = ST_MISS;
			r.found = 1'b0;
			r.value = '0;
			if (k == KIND_DEFINE) begin
				if (hit >= 0) begin
					slot_value[hit] = v;
					r.status = ST_UPDATED;
					r.found = 1'b1;
				end else if (spare >= 0) begin
					slot_key[spare] = kk;
					slot_value[spare] = v;
					slot_used[spare] = 1'b1;
					r.status = ST_INSERTED;
				end else begin
					r.status = ST_FULL;
				end
			end else if (k == KIND_LOOKUP) begin
				if (hit >= 0) begin
					r.status = ST_HIT;
					r.found = 1'b1;
					r.value = slot_value[hit];
				end
			end else if (k == KIND_DELETE) begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					r.status = ST_HIT;
					r.found = 1'b1;
				end
			end
			awaited = {awaited, r};
		endfunction

		// Compares one accepted result word with the oldest awaited one.
		function void check_result(logic [STATUS_W-1:0] st, logic fd,
				logic [VALUE_W-1:0] v);
			kv_result_t r;
			if (awaited.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word: status %0d found %0b value %h",
						st, fd, v);
				mismatches++;
			end else begin
				r = awaited.pop_front();
				if (st !== r.status || fd !== r.found || v !== r.value) begin
					if (mismatches < 10)
						$display({"result mismatch: expected status %0d found %0b value %h,",
							" got status %0d found %0b value %h"},
							r.status, r.found, r.value, st, fd, v);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	logic [KIND_W-1:0]         kind = KIND_LOOKUP;
	logic signed [KEY_W-1:0]   key = '0;
	logic signed [VALUE_W-1:0] value_in = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	logic [STATUS_W-1:0]       status;
	logic                      found;
	logic signed [VALUE_W-1:0] value_out;

	int                        send_idle_pct = 11;
	int                        recv_idle_pct = 83;
	logic [KEY_W-1:0]          key_pool [POOL_LEN];
	kvt_scoreboard             sb;

	key_value_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.key       (key),
		.value_in  (value_in),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.found     (found),
		.value_out (value_out)
	);

	always #5 clk = ~clk;

	// Result side: take accepted words and stall at random.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(status, found, value_out);
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Offers one request word, with random idle cycles ahead of it, until accepted.
	task automatic send_word(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] kk,
			input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		key <= kk;
		value_in <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(k, kk, v);
	endtask

	// Holds the request side idle until every awaited result word has come.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited.size() != 0);
	endtask

	// Deletes every key the mirror holds, so that each phase starts empty.
	task automatic clear_table();
		logic [KEY_W-1:0] held [$];
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			if (sb.slot_used[i])
				held = {held, sb.slot_key[i]};
		end
		foreach (held[i])
			send_word(KIND_DELETE, held[i], $urandom);
	endtask

	// Extreme keys and values, every kind, updates, misses and a full table.
	task automatic directed_words();
		logic [KEY_W-1:0] kk;
		send_word(KIND_DEFINE, KEY_MIN, KEY_MAX);
		send_word(KIND_DEFINE, KEY_MAX, KEY_MIN);
		send_word(KIND_LOOKUP, KEY_MIN, '0);
		send_word(KIND_DEFINE, KEY_MIN, 32'hffff_ffff);
		send_word(KIND_LOOKUP, 32'h0, 32'hffff_ffff);
		send_word(KIND_DELETE, KEY_MAX, '0);
		send_word(KIND_DELETE, KEY_MAX, '0);
		send_word(KIND_SPARE, KEY_MIN, 32'hffff_ffff);
		send_word(KIND_LOOKUP, KEY_MIN, '0);
		// Fill the remaining fifteen slots, then push one more key at a full table.
		for (int i = 0; i < 15; i++) begin
			kk = (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : 32'h1111_1111 * i;
			send_word(KIND_DEFINE, kk, ~kk);
		end
		send_word(KIND_DEFINE, 32'h0bad_f00d, 32'h5555_5555);
		send_word(KIND_DEFINE, KEY_MIN, 32'haaaa_aaaa);
		// Free a middle slot and make sure the next insert reuses it.
		send_word(KIND_DELETE, 32'h0, '0);
		send_word(KIND_DEFINE, 32'h0bad_f00d, 32'h1234_5678);
		send_word(KIND_LOOKUP, 32'h0bad_f00d, '0);
	endtask

	// Random requests, mostly on a small pool of keys so that hits and a full table occur.
	task automatic random_words(input int count);
		int               pick;
		logic [KIND_W-1:0] k;
		logic [KEY_W-1:0]  kk;
		for (int i = 0; i < POOL_LEN; i++)
			key_pool[i] = $urandom;
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			k = (pick < 42) ? KIND_DEFINE : (pick < 72) ? KIND_LOOKUP :
				(pick < 95) ? KIND_DELETE : KIND_SPARE;
			kk = key_pool[$urandom_range(POOL_LEN - 1)];
			// Stray keys are kept off defines, else they would clog the table for good.
			if (k != KIND_DEFINE && $urandom_range(9) == 0)
				kk = $urandom;
			send_word(k, kk, $urandom);
		end
	endtask

	// Main sequence: reset, directed words, then three random phases.
	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		clear_table();
		random_words(130);
		drain();
		send_idle_pct = 83;
		recv_idle_pct = 11;
		clear_table();
		random_words(130);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		clear_table();
		random_words(130);
		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("key_value_table verification clean");
		else
			$display("key_value_table verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("key_value_table verification failed");
		$finish;
	end

endmodule
